FILE: hw/rtl/akpc_pkg.sv
`timescale 1ns / 1ps

package akpc_pkg;

   localparam int MAX_WORD_DEFAULT   = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int BYTE_BITS       = 8;
   localparam int TOTAL_BITS      = 16;
   localparam int LEN_BITS        = 5;
   localparam int KEY_CHARS       = 16;
   localparam int KEY_BITS        = KEY_CHARS * BYTE_BITS;
   localparam int CHAR_INDEX_BITS = 4;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_LOW   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_LEN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_LOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_HIGH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_LEN  = 3'd5;

   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [KEY_BITS-1:0]  key_type;
   typedef logic [LEN_BITS-1:0]  len_type;

   function automatic byte_type fold_byte(input byte_type c);
      byte_type r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_alnum_byte(input byte_type c);
      return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
             (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic is_space_byte(input byte_type c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
   endfunction

   function automatic byte_type key_char(input key_type key,
                                         input logic [CHAR_INDEX_BITS-1:0] idx);
      return fold_byte(key[idx*BYTE_BITS +: BYTE_BITS]);
   endfunction

endpackage

FILE: hw/rtl/akpc_channels.sv
`timescale 1ns / 1ps

interface akpc_req_if;
   logic                            valid;
   logic                            ready;
   logic [akpc_pkg::BYTE_BITS-1:0]  text_byte;
   logic                            end_of_text;

   modport source(output valid, output text_byte, output end_of_text, input ready);
   modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface akpc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [akpc_pkg::TOTAL_BITS-1:0] pair_total;
   logic                            pair_seen;
   logic                            text_done;

   modport source(output valid, output pair_total, output pair_seen, output text_done,
                  input ready);
   modport sink(input valid, input pair_total, input pair_seen, input text_done,
                output ready);
endinterface

FILE: hw/rtl/adjacent_keyword_pair_counter_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_bus   in         text_byte[7:0], end_of_text
// rsp_bus   out        pair_total[15:0], pair_seen, text_done
// csr_*     in         csr_write_enable, csr_index[2:0], csr_write_data[63:0]
//
// Every request beat gives exactly one response beat, through the input register
// and then the response register. A new beat is accepted every cycle while the
// response is not stalled; the word state update between the two is combinational.
// Reset is synchronous and active high; it clears the text state and the keyword
// bytes and sets both keyword lengths to one. A stalled response holds both
// stages; an empty input stage still takes one beat while the response waits.

module adjacent_keyword_pair_counter_unit #(
   parameter int MAX_WORD   = akpc_pkg::MAX_WORD_DEFAULT,
   parameter int COUNT_BITS = akpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   akpc_req_if.sink                            req_bus,
   akpc_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [akpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [akpc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int POS_BITS = $clog2(MAX_WORD + 1);
   localparam int LEN_W    = akpc_pkg::LEN_BITS;
   localparam int IDX_W    = akpc_pkg::CHAR_INDEX_BITS;
   localparam int TOT_W    = akpc_pkg::TOTAL_BITS;

   localparam logic [POS_BITS-1:0]   POS_MAX   = POS_BITS'(MAX_WORD);
   localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(MAX_WORD);
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] SHOW_TOP  = COUNT_BITS'(32'd65535);

   akpc_pkg::key_type  first_key_ff, second_key_ff;
   akpc_pkg::len_type  first_len_ff, second_len_ff;

   logic               s1_valid_ff;
   akpc_pkg::byte_type s1_byte_ff;
   logic               s1_last_ff;

   logic                  inside_ff, inside_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  eq1_ff, eq1_in, eq2_ff, eq2_in;
   logic                  flag1_ff, flag1_in, flag2_ff, flag2_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  rsp_valid_ff;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic                  seen_ff, seen_in;
   logic                  done_ff;

   logic                  out_free, s1_move;
   akpc_pkg::byte_type    low_char;
   logic [IDX_W-1:0]      char_idx;
   logic                  word_in, word_end, m1, m2, pair;
   logic [POS_BITS-1:0]   pos_word;
   logic                  eq1_word, eq2_word;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pair_total = total_ff;
   assign rsp_bus.pair_seen  = seen_ff;
   assign rsp_bus.text_done  = done_ff;

   always_comb begin
      low_char = akpc_pkg::fold_byte(s1_byte_ff);
      char_idx = IDX_W'(pos_ff);
      word_in  = inside_ff;
      pos_word = pos_ff;
      eq1_word = eq1_ff;
      eq2_word = eq2_ff;

      if (!akpc_pkg::is_space_byte(s1_byte_ff)) begin
         word_in = 1'b1;
         if (akpc_pkg::is_alnum_byte(s1_byte_ff)) begin
            if (pos_ff < POS_MAX) begin
               if (LEN_W'(pos_ff) >= first_len_ff ||
                   akpc_pkg::key_char(first_key_ff, char_idx) != low_char) begin
                  eq1_word = 1'b0;
               end
               if (LEN_W'(pos_ff) >= second_len_ff ||
                   akpc_pkg::key_char(second_key_ff, char_idx) != low_char) begin
                  eq2_word = 1'b0;
               end
               pos_word = POS_BITS'(pos_ff + 1'b1);
            end else begin
               eq1_word = 1'b0;
               eq2_word = 1'b0;
            end
         end
      end

      // A whitespace byte ends an open word; any other byte leaves a word open,
      // which the last byte of the text then closes.
      word_end = akpc_pkg::is_space_byte(s1_byte_ff) ? inside_ff : s1_last_ff;

      m1 = eq1_word && first_len_ff <= LEN_MAX && LEN_W'(pos_word) == first_len_ff;
      m2 = eq2_word && second_len_ff <= LEN_MAX && LEN_W'(pos_word) == second_len_ff;

      inside_in = word_in;
      pos_in    = pos_word;
      eq1_in    = eq1_word;
      eq2_in    = eq2_word;
      flag1_in  = flag1_ff;
      flag2_in  = flag2_ff;
      count_in  = count_ff;
      pair      = 1'b0;

      if (word_end) begin
         if (m1 && !flag1_ff) begin
            flag1_in = 1'b1;
         end else if (m2 && !flag2_ff) begin
            flag2_in = 1'b1;
         end else begin
            flag1_in = 1'b0;
            flag2_in = 1'b0;
         end
         pair = flag1_in && flag2_in;
         if (pair && count_ff != COUNT_TOP) begin
            count_in = count_ff + 1'b1;
         end
         inside_in = 1'b0;
         pos_in    = '0;
         eq1_in    = 1'b1;
         eq2_in    = 1'b1;
      end

      total_in = (count_in > SHOW_TOP) ? {TOT_W{1'b1}} : TOT_W'(count_in);
      seen_in  = pair;

      if (s1_last_ff) begin
         inside_in = 1'b0;
         pos_in    = '0;
         eq1_in    = 1'b1;
         eq2_in    = 1'b1;
         flag1_in  = 1'b0;
         flag2_in  = 1'b0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_key_ff  <= '0;
         second_key_ff <= '0;
         first_len_ff  <= LEN_W'(1);
         second_len_ff <= LEN_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            akpc_pkg::CSR_FIRST_LOW:   first_key_ff[63:0]    <= csr_write_data;
            akpc_pkg::CSR_FIRST_HIGH:  first_key_ff[127:64]  <= csr_write_data;
            akpc_pkg::CSR_FIRST_LEN:   first_len_ff          <= csr_write_data[LEN_W-1:0];
            akpc_pkg::CSR_SECOND_LOW:  second_key_ff[63:0]   <= csr_write_data;
            akpc_pkg::CSR_SECOND_HIGH: second_key_ff[127:64] <= csr_write_data;
            akpc_pkg::CSR_SECOND_LEN:  second_len_ff         <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_last_ff <= req_bus.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         pos_ff    <= '0;
         eq1_ff    <= 1'b1;
         eq2_ff    <= 1'b1;
         flag1_ff  <= 1'b0;
         flag2_ff  <= 1'b0;
         count_ff  <= '0;
      end else if (s1_move) begin
         inside_ff <= inside_in;
         pos_ff    <= pos_in;
         eq1_ff    <= eq1_in;
         eq2_ff    <= eq2_in;
         flag1_ff  <= flag1_in;
         flag2_ff  <= flag2_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         total_ff <= total_in;
         seen_ff  <= seen_in;
         done_ff  <= s1_last_ff;
      end
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WORD_LIMIT        = akpc_pkg::MAX_WORD_DEFAULT;
   localparam int PAIR_MAX          = (1 << akpc_pkg::COUNT_BITS_DEFAULT) - 1;
   localparam int CYCLE_LIMIT       = 200_000;
   localparam int BEATS_PER_SETTING = 38;

   typedef struct packed {
      logic [akpc_pkg::TOTAL_BITS-1:0] total;
      logic                            seen;
      logic                            done;
   } pair_result_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_write_enable;
   logic [akpc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [akpc_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   akpc_req_if req_bus ();
   akpc_rsp_if rsp_bus ();

   adjacent_keyword_pair_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int beats_sent     = 0;

   pair_result_type expected_results[$];

   logic [63:0]                   key_low_reg [2];
   logic [63:0]                   key_high_reg [2];
   logic [akpc_pkg::LEN_BITS-1:0] key_len_reg [2];
   logic                          in_word;
   logic                          still_one;
   logic                          still_two;
   logic                          flag_one;
   logic                          flag_two;
   int                            kept_count;
   int                            pair_count;

   akpc_pkg::byte_type key_chars [2][akpc_pkg::KEY_CHARS];
   int                 key_length [2];

   function automatic logic is_letter(input akpc_pkg::byte_type c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_word_char(input akpc_pkg::byte_type c);
      return is_letter(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_blank(input akpc_pkg::byte_type c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic akpc_pkg::byte_type lower_case(input akpc_pkg::byte_type c);
      if (c >= "A" && c <= "Z") begin
         return c | 8'h20;
      end
      return c;
   endfunction

   function automatic akpc_pkg::byte_type keyword_letter(input int k, input int pos);
      logic [63:0] lane;
      lane = (pos < 8) ? key_low_reg[k] : key_high_reg[k];
      return lower_case(lane[(pos % 8) * 8 +: 8]);
   endfunction

   function automatic void clear_text();
      in_word    = 1'b0;
      kept_count = 0;
      still_one  = 1'b1;
      still_two  = 1'b1;
      flag_one   = 1'b0;
      flag_two   = 1'b0;
      pair_count = 0;
   endfunction

   function automatic logic close_word();
      logic hit_one;
      logic hit_two;
      logic completed;
      hit_one = still_one && key_len_reg[0] <= WORD_LIMIT && kept_count == int'(key_len_reg[0]);
      hit_two = still_two && key_len_reg[1] <= WORD_LIMIT && kept_count == int'(key_len_reg[1]);
      completed = 1'b0;
      if (hit_one && !flag_one) begin
         flag_one = 1'b1;
      end else if (hit_two && !flag_two) begin
         flag_two = 1'b1;
      end else begin
         flag_one = 1'b0;
         flag_two = 1'b0;
      end
      if (flag_one && flag_two) begin
         completed = 1'b1;
         if (pair_count < PAIR_MAX) begin
            pair_count++;
         end
      end
      in_word    = 1'b0;
      kept_count = 0;
      still_one  = 1'b1;
      still_two  = 1'b1;
      return completed;
   endfunction

   function automatic void predict_beat(input akpc_pkg::byte_type b, input logic last);
      pair_result_type    r;
      logic               paired;
      akpc_pkg::byte_type lc;
      paired = 1'b0;
      if (is_blank(b)) begin
         if (in_word) begin
            paired = close_word();
         end
      end else begin
         in_word = 1'b1;
         if (is_word_char(b)) begin
            lc = lower_case(b);
            if (kept_count < WORD_LIMIT) begin
               if (kept_count >= int'(key_len_reg[0]) || keyword_letter(0, kept_count) != lc) begin
                  still_one = 1'b0;
               end
               if (kept_count >= int'(key_len_reg[1]) || keyword_letter(1, kept_count) != lc) begin
                  still_two = 1'b0;
               end
               kept_count++;
            end else begin
               still_one = 1'b0;
               still_two = 1'b0;
            end
         end
      end
      if (last && in_word) begin
         if (close_word()) begin
            paired = 1'b1;
         end
      end
      r.total = pair_count[akpc_pkg::TOTAL_BITS-1:0];
      r.seen  = paired;
      r.done  = last;
      expected_results.push_back(r);
      if (last) begin
         clear_text();
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      $display("Mismatch in %s at cycle %0d: got %0d, expected %0d",
               field, cycle_count, got, want);
   endtask

   always @(posedge clock) begin
      pair_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat", int'(rsp_bus.pair_total), -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.pair_total !== want.total) begin
               report_mismatch("pair_total", int'(rsp_bus.pair_total), int'(want.total));
            end
            if (rsp_bus.pair_seen !== want.seen) begin
               report_mismatch("pair_seen", int'(rsp_bus.pair_seen), int'(want.seen));
            end
            if (rsp_bus.text_done !== want.done) begin
               report_mismatch("text_done", int'(rsp_bus.text_done), int'(want.done));
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_text_byte(input akpc_pkg::byte_type b, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_beat(b, last);
      beats_sent++;
   endtask

   task automatic send_chars(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_text_byte(s[i], 1'b0);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [akpc_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [akpc_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         akpc_pkg::CSR_FIRST_LOW:   key_low_reg[0]  = data;
         akpc_pkg::CSR_FIRST_HIGH:  key_high_reg[0] = data;
         akpc_pkg::CSR_FIRST_LEN:   key_len_reg[0]  = data[akpc_pkg::LEN_BITS-1:0];
         akpc_pkg::CSR_SECOND_LOW:  key_low_reg[1]  = data;
         akpc_pkg::CSR_SECOND_HIGH: key_high_reg[1] = data;
         akpc_pkg::CSR_SECOND_LEN:  key_len_reg[1]  = data[akpc_pkg::LEN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic program_keywords();
      logic [63:0] packed_low;
      logic [63:0] packed_high;
      logic [63:0] len_word;
      int          i;
      drain_results();
      for (i = 0; i < 8; i++) begin
         packed_low[i*8 +: 8]  = key_chars[0][i];
         packed_high[i*8 +: 8] = key_chars[0][i+8];
      end
      len_word = {$urandom, $urandom};
      len_word[akpc_pkg::LEN_BITS-1:0] = key_length[0][akpc_pkg::LEN_BITS-1:0];
      write_register(akpc_pkg::CSR_FIRST_LOW, packed_low);
      write_register(akpc_pkg::CSR_FIRST_HIGH, packed_high);
      write_register(akpc_pkg::CSR_FIRST_LEN, len_word);
      for (i = 0; i < 8; i++) begin
         packed_low[i*8 +: 8]  = key_chars[1][i];
         packed_high[i*8 +: 8] = key_chars[1][i+8];
      end
      len_word = {$urandom, $urandom};
      len_word[akpc_pkg::LEN_BITS-1:0] = key_length[1][akpc_pkg::LEN_BITS-1:0];
      write_register(akpc_pkg::CSR_SECOND_LOW, packed_low);
      write_register(akpc_pkg::CSR_SECOND_HIGH, packed_high);
      write_register(akpc_pkg::CSR_SECOND_LEN, len_word);
      csr_write_enable <= 1'b0;
   endtask

   function automatic akpc_pkg::byte_type random_alnum();
      case ($urandom_range(2))
         0: return akpc_pkg::byte_type'("0" + $urandom_range(9));
         1: return akpc_pkg::byte_type'("a" + $urandom_range(25));
         default: return akpc_pkg::byte_type'("A" + $urandom_range(25));
      endcase
   endfunction

   function automatic akpc_pkg::byte_type filler_byte();
      case ($urandom_range(3))
         0: return akpc_pkg::byte_type'($urandom_range(128, 255));
         1: return akpc_pkg::byte_type'($urandom_range(0, 8));
         2: return akpc_pkg::byte_type'($urandom_range(14, 31));
         default: return akpc_pkg::byte_type'("!" + $urandom_range(14));
      endcase
   endfunction

   function automatic akpc_pkg::byte_type blank_byte();
      int r;
      r = $urandom_range(5);
      return (r == 5) ? akpc_pkg::byte_type'(" ") : akpc_pkg::byte_type'(9 + r);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         return 0;
      end else if (r < 20) begin
         return WORD_LIMIT;
      end else if (r < 28) begin
         return $urandom_range(WORD_LIMIT + 1, 31);
      end
      return $urandom_range(1, 6);
   endfunction

   function automatic void set_keyword(input int k, input string s, input int len);
      int i;
      for (i = 0; i < akpc_pkg::KEY_CHARS; i++) begin
         key_chars[k][i] = (i < s.len()) ? akpc_pkg::byte_type'(s[i]) :
                                           akpc_pkg::byte_type'($urandom_range(255));
      end
      key_length[k] = len;
   endfunction

   function automatic void make_random_keyword(input int k, input int len);
      int i;
      for (i = 0; i < akpc_pkg::KEY_CHARS; i++) begin
         if (i >= len) begin
            key_chars[k][i] = akpc_pkg::byte_type'($urandom_range(255));
         end else if ($urandom_range(14) == 0) begin
            key_chars[k][i] = filler_byte();
         end else begin
            key_chars[k][i] = random_alnum();
         end
      end
      key_length[k] = len;
   endfunction

   task automatic append_keyword(ref akpc_pkg::byte_type text[$], input int k,
                                 input logic overlong);
      int                 i;
      int                 n;
      akpc_pkg::byte_type c;
      n = (key_length[k] < WORD_LIMIT) ? key_length[k] : WORD_LIMIT;
      for (i = 0; i < n; i++) begin
         c = key_chars[k][i];
         if (is_letter(c) && $urandom_range(1) == 1) begin
            c = c ^ 8'h20;
         end
         text.push_back(c);
         if ($urandom_range(9) == 0) begin
            text.push_back(filler_byte());
         end
      end
      if (overlong) begin
         text.push_back(random_alnum());
      end
   endtask

   task automatic send_random_text(input int budget);
      akpc_pkg::byte_type text[$];
      int                 i;
      int                 pick;
      while (text.size() < budget) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            append_keyword(text, 0, 1'b0);
         end else if (pick < 70) begin
            append_keyword(text, 1, 1'b0);
         end else if (pick < 78) begin
            append_keyword(text, $urandom_range(1), 1'b1);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 20)) text.push_back(random_alnum());
         end else begin
            repeat ($urandom_range(1, 3)) text.push_back(akpc_pkg::byte_type'($urandom_range(255)));
         end
         if ($urandom_range(9) != 0) begin
            repeat ($urandom_range(1, 2)) text.push_back(blank_byte());
         end
      end
      for (i = 0; i < text.size(); i++) begin
         send_text_byte(text[i], i == text.size() - 1);
      end
   endtask

   task automatic test_default_keywords();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(" ", 1'b0);
      send_text_byte("a", 1'b1);
   endtask

   task automatic test_directed_words();
      set_keyword(0, "Ab", 2);
      set_keyword(1, "c9", 2);
      program_keywords();
      send_chars("Ab");
      send_text_byte(8'h09, 1'b0);
      send_chars("c9");
      send_text_byte(8'h0a, 1'b0);
      send_chars("c-9");
      send_text_byte(8'h0d, 1'b0);
      send_text_byte(8'h80, 1'b0);
      send_text_byte(8'hff, 1'b0);
      send_text_byte(8'h0c, 1'b0);
      send_chars("a");
      send_text_byte("B", 1'b1);
      // An empty keyword matches a word with no letters or digits; length 20 matches nothing.
      set_keyword(0, "", 0);
      set_keyword(1, "xyz", 20);
      program_keywords();
      send_text_byte("!", 1'b0);
      send_text_byte(" ", 1'b0);
      send_text_byte("#", 1'b0);
      send_text_byte(8'h0b, 1'b0);
      send_text_byte(" ", 1'b1);
   endtask

   task automatic test_random_texts(input int phase);
      int setting;
      int g;
      int target;
      int i;
      for (setting = 0; setting < 3; setting++) begin
         g = phase * 3 + setting;
         make_random_keyword(0, pick_length());
         make_random_keyword(1, pick_length());
         case (g)
            0: begin
               make_random_keyword(0, WORD_LIMIT);
               make_random_keyword(1, 0);
            end
            1: begin
               make_random_keyword(0, 31);
               make_random_keyword(1, WORD_LIMIT);
            end
            2: begin
               key_chars[1]  = key_chars[0];
               key_length[1] = key_length[0];
            end
            3: begin
               for (i = 0; i < akpc_pkg::KEY_CHARS; i++) begin
                  key_chars[0][i] = 8'hff;
               end
               key_length[0] = WORD_LIMIT;
            end
            default: ;
         endcase
         program_keywords();
         target = beats_sent + BEATS_PER_SETTING;
         while (beats_sent < target) begin
            send_random_text($urandom_range(4, 30));
            if ($urandom_range(5) == 0) begin
               drain_results();
            end
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.text_byte   <= '0;
      req_bus.end_of_text <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      key_low_reg[0]  = '0;
      key_high_reg[0] = '0;
      key_len_reg[0]  = 5'd1;
      key_low_reg[1]  = '0;
      key_high_reg[1] = '0;
      key_len_reg[1]  = 5'd1;
      clear_text();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 52;
      test_default_keywords();
      test_directed_words();
      test_random_texts(0);
      send_idle_pct = 52;
      recv_idle_pct = 13;
      test_random_texts(1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_texts(2);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/akpc_pkg.sv
hw/rtl/akpc_channels.sv
hw/rtl/adjacent_keyword_pair_counter_unit.sv
verif/tb.sv
